// File: src/lcfp_pkg.sv
// ----------------------------------------------------------------------------
// LED command frame parser package
// Shared character constants, the result record and the command decoder.
// ----------------------------------------------------------------------------
package lcfp_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] CODE_F     = 4'd0;
    localparam logic [3:0] CODE_R     = 4'd1;
    localparam logic [3:0] CODE_G     = 4'd2;
    localparam logic [3:0] CODE_B     = 4'd3;
    localparam logic [3:0] CODE_H     = 4'd4;
    localparam logic [3:0] CODE_V     = 4'd5;
    localparam logic [3:0] CODE_T     = 4'd6;
    localparam logic [3:0] CODE_C     = 4'd7;
    localparam logic [3:0] CODE_K     = 4'd8;
    localparam logic [3:0] CODE_P     = 4'd9;
    localparam logic [3:0] CODE_W     = 4'd10;
    localparam logic [3:0] CODE_X     = 4'd11;
    localparam logic [3:0] CODE_I     = 4'd12;
    localparam logic [3:0] CODE_A     = 4'd13;
    localparam logic [3:0] CODE_OTHER = 4'd14;

    localparam int TDATA_W = 32;

    typedef struct packed {
        logic        was_addressed;
        logic [15:0] argument;
        logic [7:0]  command_char;
        logic [3:0]  command_code;
    } result_t;

    function automatic logic [3:0] code_of(input logic [7:0] c);
        logic [3:0] code;
        unique case (c)
            "F":     code = CODE_F;
            "R":     code = CODE_R;
            "G":     code = CODE_G;
            "B":     code = CODE_B;
            "H":     code = CODE_H;
            "V":     code = CODE_V;
            "T":     code = CODE_T;
            "C":     code = CODE_C;
            "K":     code = CODE_K;
            "P":     code = CODE_P;
            "W":     code = CODE_W;
            "X":     code = CODE_X;
            "I":     code = CODE_I;
            "A":     code = CODE_A;
            "a":     code = CODE_A;
            default: code = CODE_OTHER;
        endcase
        return code;
    endfunction

endpackage

// File: src/lcfp_parser.sv
// ----------------------------------------------------------------------------
// LED command frame parser state machine
// Updates the frame state for each accepted byte and flags a finished frame.
// ----------------------------------------------------------------------------
module lcfp_parser #(
    parameter int FRAME_CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        node_address,
    output logic              emit,
    output lcfp_pkg::result_t result
);

    localparam int PosW = $clog2(FRAME_CAPACITY + 1);
    localparam logic [PosW-1:0] PosCap = PosW'(FRAME_CAPACITY);
    localparam logic [PosW-1:0] PosOne = PosW'(1);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WANT_L    = 3'd1,
        PH_WANT_ADDR = 3'd2,
        PH_WANT_CMD  = 3'd3,
        PH_DIGITS    = 3'd4,
        PH_TAIL      = 3'd5,
        PH_SKIP      = 3'd6
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [15:0]     accum_reg, accum_next;
    logic            addr_reg, addr_next;
    logic            emit_next;
    logic            room;
    logic            is_digit;
    logic            is_close;
    logic [7:0]      digit_value;
    logic [15:0]     accum_step;

    assign room        = pos_reg < PosCap;
    assign is_digit    = (rx_byte >= lcfp_pkg::CH_ZERO) && (rx_byte <= lcfp_pkg::CH_NINE);
    assign is_close    = rx_byte == lcfp_pkg::CH_CLOSE;
    assign digit_value = rx_byte - lcfp_pkg::CH_ZERO;
    assign accum_step  = {accum_reg[12:0], 3'b000} + {accum_reg[14:0], 1'b0}
                         + {8'd0, digit_value};

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        accum_next = accum_reg;
        addr_next  = addr_reg;
        emit_next  = 1'b0;
        if (rx_byte == lcfp_pkg::CH_OPEN)
        begin
            phase_next = PH_WANT_L;
            pos_next   = PosOne;
            cmd_next   = 8'd0;
            accum_next = 16'd0;
            addr_next  = 1'b0;
        end
        else
        begin
            if (room && phase_reg != PH_IDLE)
            begin
                pos_next = pos_reg + PosOne;
            end
            unique case (phase_reg)
                PH_WANT_L:
                begin
                    if (is_close)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (rx_byte == lcfp_pkg::CH_L)
                    begin
                        phase_next = PH_WANT_ADDR;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_WANT_ADDR:
                begin
                    if (is_digit)
                    begin
                        if (digit_value == node_address)
                        begin
                            addr_next  = 1'b1;
                            phase_next = PH_WANT_CMD;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        cmd_next = rx_byte;
                        if (is_close)
                        begin
                            emit_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_DIGITS;
                        end
                    end
                end
                PH_WANT_CMD:
                begin
                    cmd_next = rx_byte;
                    if (is_close)
                    begin
                        emit_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_DIGITS;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_close)
                    begin
                        emit_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (room)
                    begin
                        if (is_digit)
                        begin
                            accum_next = accum_step;
                        end
                        else
                        begin
                            phase_next = PH_TAIL;
                        end
                    end
                end
                PH_TAIL:
                begin
                    if (is_close)
                    begin
                        emit_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_SKIP:
                begin
                    if (is_close)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            cmd_reg   <= 8'd0;
            accum_reg <= 16'd0;
            addr_reg  <= 1'b0;
        end
        else if (byte_valid)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            accum_reg <= accum_next;
            addr_reg  <= addr_next;
        end
    end

    assign emit                 = byte_valid && emit_next;
    assign result.command_code  = lcfp_pkg::code_of(cmd_next);
    assign result.command_char  = cmd_next;
    assign result.argument      = accum_reg;
    assign result.was_addressed = addr_reg;

`ifndef SYNTHESIS
    a_emit_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> is_close)
        else $error("Frame finished on a byte other than the closing mark.");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> phase_reg == PH_IDLE)
        else $error("Parser did not return to idle after a finished frame.");

    a_open_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && rx_byte == lcfp_pkg::CH_OPEN |=>
        phase_reg == PH_WANT_L && pos_reg == PosOne && accum_reg == 16'd0)
        else $error("Opening mark did not restart the frame.");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosCap)
        else $error("Frame byte count ran past capacity.");
`endif

endmodule

// File: src/led_command_frame_parser_core.sv
// ----------------------------------------------------------------------------
// LED command frame parser core
// Parses framed ASCII LED commands; emits at most one decoded command per frame.
// ----------------------------------------------------------------------------
// A result appears on the master side in the cycle after its closing byte
// is taken. Throughput: one byte per cycle through the parser and one output
// register while no pending result is stalled. Reset clears the parser to
// idle, the node address to zero and the output register to empty.
module led_command_frame_parser_core #(
    parameter int FRAME_CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // rx_byte [7:0]
    input  logic [7:0]                   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // command_code [3:0], command_char [11:4], argument [27:12],
    // was_addressed [28], zero [31:29]
    output logic [lcfp_pkg::TDATA_W-1:0] m_tdata
);

    logic              in_xfer;
    logic              emit;
    lcfp_pkg::result_t result;
    lcfp_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic [7:0]        node_address_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            node_address_reg <= cfg_data;
        end
    end

    lcfp_parser #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (in_xfer),
        .rx_byte      (s_tdata),
        .node_address (node_address_reg),
        .emit         (emit),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lcfp_pkg::TDATA_W - $bits(lcfp_pkg::result_t)){1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !emit)
        else $error("Pending result overwritten by a new frame.");

    a_result_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("Finished frame produced no output transfer.");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("Stalled result changed before its transfer.");
`endif

endmodule
